// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/esd_pkg.sv =====
// ---------------------------------------------------------------------------
// esd_pkg
// shared types and constants of the escape sequence decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package esd_pkg;

  localparam int TABLE_SLOTS    = 10;
  localparam int MAX_HEX_DIGITS = 2;
  localparam int MAX_OCT_DIGITS = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X_LOWER   = 8'h78;
  localparam logic [7:0] CH_X_UPPER   = 8'h58;
  localparam logic [7:0] CH_DIG_0     = 8'h30;
  localparam logic [7:0] CH_DIG_7     = 8'h37;
  localparam logic [7:0] CH_DIG_9     = 8'h39;
  localparam logic [7:0] CH_A_LOWER   = 8'h61;
  localparam logic [7:0] CH_F_LOWER   = 8'h66;
  localparam logic [7:0] CH_A_UPPER   = 8'h41;
  localparam logic [7:0] CH_F_UPPER   = 8'h46;

  // register reset values
  localparam logic [3:0]  RST_KEY_COUNT  = 4'd10;
  localparam logic [31:0] RST_KEYS_WORD0 = 32'd1852203617;
  localparam logic [31:0] RST_KEYS_WORD1 = 32'd1551266930;
  localparam logic [15:0] RST_KEYS_WORD2 = 16'd8743;
  localparam logic [31:0] RST_REPL_WORD0 = 32'd168560647;
  localparam logic [31:0] RST_REPL_WORD1 = 32'd1544227085;
  localparam logic [15:0] RST_REPL_WORD2 = 16'd8743;

  typedef enum logic [2:0] {
    CFG_KEY_COUNT  = 3'd0,
    CFG_KEYS_WORD0 = 3'd1,
    CFG_KEYS_WORD1 = 3'd2,
    CFG_KEYS_WORD2 = 3'd3,
    CFG_REPL_WORD0 = 3'd4,
    CFG_REPL_WORD1 = 3'd5,
    CFG_REPL_WORD2 = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2,
    MODE_OCT  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [3:0]  key_count;
    logic [79:0] keys;
    logic [79:0] repls;
  } cfg_t;

  typedef struct packed {
    logic [8:0] value;
    logic       eos;
  } res_t;

  // one decoded input byte: one or two results
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

// ===== hw/rtl/esd_front.sv =====
// ---------------------------------------------------------------------------
// esd_front
// accepts raw bytes, runs the escape state machine, emits decoded entries
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module esd_front import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_push,
  input  logic [7:0] in_byte,
  input  logic       fifo_full,
  output logic       in_full,
  output logic       fifo_push,
  output entry_t     fifo_entry
);

  mode_t      mode_r, mode_nxt;
  logic [8:0] acc_r, acc_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;
  logic [7:0] hexl_r, hexl_nxt;

  logic       accept;
  logic [3:0] n_used;
  logic [7:0] repl;
  logic       lookup_done;
  logic [4:0] hex_d;
  logic       is_oct;
  logic [1:0] dcnt_inc;
  logic       idle_esc;
  res_t       idle_res;
  logic [1:0] n_res;
  res_t       r0, r1;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd0;
    if (c >= CH_DIG_0 && c <= CH_DIG_9)
      d = {1'b1, c[3:0]};
    else if ((c >= CH_A_LOWER && c <= CH_F_LOWER) || (c >= CH_A_UPPER && c <= CH_F_UPPER))
      d = {1'b1, 4'(c[3:0] + 4'd9)};
    return d;
  endfunction

  assign accept  = in_push && !fifo_full;
  assign in_full = fifo_full;

  // first matching key wins, a zero key ends the table
  always_comb begin
    n_used      = (cfg.key_count > 4'(TABLE_SLOTS)) ? 4'(TABLE_SLOTS) : cfg.key_count;
    repl        = 8'd0;
    lookup_done = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!lookup_done && 4'(i) < n_used) begin
        if (cfg.keys[8*i +: 8] == 8'd0) begin
          lookup_done = 1'b1;
        end else if (cfg.keys[8*i +: 8] == in_byte) begin
          repl        = cfg.repls[8*i +: 8];
          lookup_done = 1'b1;
        end
      end
    end
  end

  assign hex_d    = hex_digit(in_byte);
  assign is_oct   = (in_byte >= CH_DIG_0) && (in_byte <= CH_DIG_7);
  assign dcnt_inc = 2'(dcnt_r + 2'd1);
  assign idle_esc = (in_byte == CH_BACKSLASH);
  assign idle_res = '{value: {1'b0, in_byte}, eos: (in_byte == CH_NUL)};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dcnt_nxt = dcnt_r;
    hexl_nxt = hexl_r;
    n_res    = 2'd0;
    r0       = '0;
    r1       = '0;
    unique case (mode_r)
      MODE_IDLE: begin
        if (idle_esc) begin
          mode_nxt = MODE_ESC;
        end else begin
          r0    = idle_res;
          n_res = 2'd1;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_IDLE;
        if (repl != 8'd0) begin
          r0    = '{value: {1'b0, repl}, eos: 1'b0};
          n_res = 2'd1;
        end else if (in_byte == CH_X_LOWER || in_byte == CH_X_UPPER) begin
          mode_nxt = MODE_HEX;
          acc_nxt  = 9'd0;
          dcnt_nxt = 2'd0;
          hexl_nxt = in_byte;
        end else if (is_oct) begin
          acc_nxt  = {6'd0, in_byte[2:0]};
          dcnt_nxt = 2'd1;
          if (2'd1 >= 2'(MAX_OCT_DIGITS)) begin
            r0    = '{value: {6'd0, in_byte[2:0]}, eos: 1'b0};
            n_res = 2'd1;
          end else begin
            mode_nxt = MODE_OCT;
          end
        end else if (in_byte == CH_NUL) begin
          r0    = '{value: 9'd0, eos: 1'b0};
          r1    = '{value: 9'd0, eos: 1'b1};
          n_res = 2'd2;
        end else begin
          r0    = idle_res;
          n_res = 2'd1;
        end
      end
      MODE_HEX: begin
        if (hex_d[4]) begin
          acc_nxt  = {acc_r[4:0], hex_d[3:0]};
          dcnt_nxt = dcnt_inc;
          if (dcnt_inc >= 2'(MAX_HEX_DIGITS)) begin
            mode_nxt = MODE_IDLE;
            r0       = '{value: {acc_r[4:0], hex_d[3:0]}, eos: 1'b0};
            n_res    = 2'd1;
          end
        end else begin
          // pending value, then the byte as if idle
          mode_nxt = idle_esc ? MODE_ESC : MODE_IDLE;
          r0       = '{value: (dcnt_r == 2'd0) ? {1'b0, hexl_r} : acc_r, eos: 1'b0};
          r1       = idle_res;
          n_res    = idle_esc ? 2'd1 : 2'd2;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          acc_nxt  = {acc_r[5:0], in_byte[2:0]};
          dcnt_nxt = dcnt_inc;
          if (dcnt_inc >= 2'(MAX_OCT_DIGITS)) begin
            mode_nxt = MODE_IDLE;
            r0       = '{value: {acc_r[5:0], in_byte[2:0]}, eos: 1'b0};
            n_res    = 2'd1;
          end
        end else begin
          mode_nxt = idle_esc ? MODE_ESC : MODE_IDLE;
          r0       = '{value: acc_r, eos: 1'b0};
          r1       = idle_res;
          n_res    = idle_esc ? 2'd1 : 2'd2;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  assign fifo_push  = accept && (n_res != 2'd0);
  assign fifo_entry = '{two: (n_res == 2'd2), r0: r0, r1: r1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= 9'd0;
      dcnt_r <= 2'd0;
      hexl_r <= 8'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dcnt_r <= dcnt_nxt;
      hexl_r <= hexl_nxt;
    end
  end

endmodule

// ===== hw/rtl/esd_fifo.sv =====
// ---------------------------------------------------------------------------
// esd_fifo
// short entry queue between the decode front and the output back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module esd_fifo import esd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   full,
  output logic   empty
);

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)
      count_nxt = (FIFO_AW+1)'(count_r + 1'b1);
    else if (do_pop && !do_push)
      count_nxt = (FIFO_AW+1)'(count_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule

// ===== hw/rtl/esd_back.sv =====
// ---------------------------------------------------------------------------
// esd_back
// output register, delivers the one or two results of each entry in turn
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module esd_back import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     fifo_entry,
  input  logic       fifo_empty,
  output logic       fifo_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [8:0] out_char_value,
  output logic       out_end_of_string,
  output logic       out_last
);

  entry_t hold_r, hold_nxt;
  logic   valid_r, valid_nxt;
  logic   phase_r, phase_nxt;
  logic   take, cur_last;
  res_t   cur;

  assign take     = valid_r && out_pop;
  assign cur_last = !hold_r.two || phase_r;
  assign cur      = phase_r ? hold_r.r1 : hold_r.r0;

  always_comb begin
    hold_nxt  = hold_r;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    fifo_pop  = 1'b0;
    if (!valid_r || (take && cur_last)) begin
      fifo_pop  = !fifo_empty;
      valid_nxt = !fifo_empty;
      hold_nxt  = fifo_entry;
      phase_nxt = 1'b0;
    end else if (take) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign out_empty         = !valid_r;
  assign out_char_value    = cur.value;
  assign out_end_of_string = cur.eos;
  assign out_last          = cur_last;

endmodule

// ===== hw/rtl/escape_sequence_decoder.sv =====
// ---------------------------------------------------------------------------
// escape_sequence_decoder: one raw byte per cycle in, one result per cycle out
//   while in_full is low and out_pop is high; a taken byte's results pass
//   through the entry queue, then the output register once it is free
// throughput: 1 byte per cycle while not in_full; a two-result byte holds the
//   output register until both are taken, the 4-entry queue absorbs bursts
// reset: synchronous active low, clears state and queue, sets table defaults
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module escape_sequence_decoder import esd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // raw byte input
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte,
  // decoded results
  output logic        out_empty,
  input  logic        out_pop,
  output logic [8:0]  out_char_value,
  output logic        out_end_of_string,
  output logic        out_last
);

  // configuration registers
  logic [3:0]  key_count_r;
  logic [31:0] keys_word0_r, keys_word1_r, repl_word0_r, repl_word1_r;
  logic [15:0] keys_word2_r, repl_word2_r;
  logic        cfg_wr;
  cfg_t        cfg;

  // front to queue, queue to back
  logic   fifo_push, fifo_full, fifo_pop, fifo_empty;
  entry_t fifo_wr_entry, fifo_rd_entry;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r  <= RST_KEY_COUNT;
      keys_word0_r <= RST_KEYS_WORD0;
      keys_word1_r <= RST_KEYS_WORD1;
      keys_word2_r <= RST_KEYS_WORD2;
      repl_word0_r <= RST_REPL_WORD0;
      repl_word1_r <= RST_REPL_WORD1;
      repl_word2_r <= RST_REPL_WORD2;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_KEY_COUNT:  key_count_r  <= cfg_data[3:0];
        CFG_KEYS_WORD0: keys_word0_r <= cfg_data;
        CFG_KEYS_WORD1: keys_word1_r <= cfg_data;
        CFG_KEYS_WORD2: keys_word2_r <= cfg_data[15:0];
        CFG_REPL_WORD0: repl_word0_r <= cfg_data;
        CFG_REPL_WORD1: repl_word1_r <= cfg_data;
        CFG_REPL_WORD2: repl_word2_r <= cfg_data[15:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // table entries packed low byte first
  assign cfg = '{
    key_count: key_count_r,
    keys:      {keys_word2_r, keys_word1_r, keys_word0_r},
    repls:     {repl_word2_r, repl_word1_r, repl_word0_r}
  };

  // decode front: classifies each byte and updates the escape state
  esd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_push    (in_push),
    .in_byte    (in_byte),
    .fifo_full  (fifo_full),
    .in_full    (in_full),
    .fifo_push  (fifo_push),
    .fifo_entry (fifo_wr_entry)
  );

  // decouples decode from output stalls
  esd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .wr_entry (fifo_wr_entry),
    .pop      (fifo_pop),
    .rd_entry (fifo_rd_entry),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  // output back: splits entries into single result transactions
  esd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .fifo_entry        (fifo_rd_entry),
    .fifo_empty        (fifo_empty),
    .fifo_pop          (fifo_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_char_value    (out_char_value),
    .out_end_of_string (out_end_of_string),
    .out_last          (out_last)
  );

  // front never pushes into a full queue
  `ASSERT_IMP(a_no_push_when_full, clk, rst_n, fifo_full, !fifo_push)
  // end marker is always the final result of its byte
  `ASSERT_IMP(a_eos_is_last, clk, rst_n, !out_empty && out_end_of_string, out_last)
  // end marker carries a zero value
  `ASSERT_IMP(a_eos_zero, clk, rst_n, !out_empty && out_end_of_string, out_char_value == 9'd0)
  // second result of a byte follows right after the first is taken
  `ASSERT_NXT(a_second_follows, clk, rst_n, !out_empty && !out_last && out_pop, !out_empty)

endmodule
